@@ hdl/cae_pkg.sv @@
// Shared types, constants and the step microprogram for the attractor stepper.
package cae_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 24;
  localparam int unsigned ProdW = 2 * WordW;
  localparam int unsigned QuotW = ProdW - FracW;

  typedef logic signed [WordW-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_SIGMA   = 3'd0,
    REG_RHO     = 3'd1,
    REG_BETA    = 3'd2,
    REG_DT      = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6,
    REG_COUNT   = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MULA = 2'd2,
    OP_MULB = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    SRC_X  = 4'd0,
    SRC_Y  = 4'd1,
    SRC_Z  = 4'd2,
    SRC_T0 = 4'd3,
    SRC_T1 = 4'd4,
    SRC_T2 = 4'd5,
    SRC_T3 = 4'd6,
    SRC_SG = 4'd7,
    SRC_RH = 4'd8,
    SRC_BT = 4'd9,
    SRC_DT = 4'd10
  } src_e;

  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_X    = 3'd1,
    DST_Y    = 3'd2,
    DST_Z    = 3'd3,
    DST_T0   = 3'd4,
    DST_T1   = 3'd5,
    DST_T2   = 3'd6,
    DST_T3   = 3'd7
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e src_a;
    src_e src_b;
    dst_e dst;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic exec;
    logic load_start;
    logic step_start;
    logic last_step;
    logic commit;
  } ctrl_t;

  localparam int unsigned ProgLen = 21;
  localparam int unsigned PcW     = $clog2(ProgLen);

  // All derivatives are formed from the old point before any coordinate is
  // overwritten, so x, y and z can be updated in place at the end.
  localparam uop_t Prog [ProgLen] = '{
    '{OP_SUB,  SRC_Y,  SRC_X,  DST_T0},
    '{OP_MULA, SRC_SG, SRC_T0, DST_NONE},
    '{OP_MULB, SRC_X,  SRC_X,  DST_T0},
    '{OP_SUB,  SRC_RH, SRC_Z,  DST_T1},
    '{OP_MULA, SRC_X,  SRC_T1, DST_NONE},
    '{OP_MULB, SRC_X,  SRC_X,  DST_T1},
    '{OP_SUB,  SRC_T1, SRC_Y,  DST_T1},
    '{OP_MULA, SRC_X,  SRC_Y,  DST_NONE},
    '{OP_MULB, SRC_X,  SRC_X,  DST_T2},
    '{OP_MULA, SRC_BT, SRC_Z,  DST_NONE},
    '{OP_MULB, SRC_X,  SRC_X,  DST_T3},
    '{OP_SUB,  SRC_T2, SRC_T3, DST_T2},
    '{OP_MULA, SRC_DT, SRC_T0, DST_NONE},
    '{OP_MULB, SRC_X,  SRC_X,  DST_T3},
    '{OP_ADD,  SRC_X,  SRC_T3, DST_X},
    '{OP_MULA, SRC_DT, SRC_T1, DST_NONE},
    '{OP_MULB, SRC_X,  SRC_X,  DST_T3},
    '{OP_ADD,  SRC_Y,  SRC_T3, DST_Y},
    '{OP_MULA, SRC_DT, SRC_T2, DST_NONE},
    '{OP_MULB, SRC_X,  SRC_X,  DST_T3},
    '{OP_ADD,  SRC_Z,  SRC_T3, DST_Z}
  };

  localparam logic [PcW-1:0] PcLast = PcW'(ProgLen - 1);

endpackage

@@ hdl/cae_alu.sv @@
// Shared saturating adder and registered fixed-point multiplier.
module cae_alu (
  input  logic             clk_i,
  input  cae_pkg::op_e     op_i,
  input  logic             en_i,
  input  cae_pkg::word_t   a_i,
  input  cae_pkg::word_t   b_i,
  output cae_pkg::word_t   res_o,
  output logic             ovf_o
);

  logic signed [cae_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [cae_pkg::ProdW-1:0] biased;
  logic signed [cae_pkg::ProdW-1:0] shifted;
  logic signed [cae_pkg::QuotW-1:0] quot;
  logic signed [cae_pkg::WordW:0]   sum;
  logic                             sum_ovf;
  logic                             quot_ovf;
  cae_pkg::word_t                   sum_res;
  cae_pkg::word_t                   quot_res;

  always_comb begin
    if (op_i == cae_pkg::OP_SUB) begin
      sum = {a_i[cae_pkg::WordW-1], a_i} - {b_i[cae_pkg::WordW-1], b_i};
    end else begin
      sum = {a_i[cae_pkg::WordW-1], a_i} + {b_i[cae_pkg::WordW-1], b_i};
    end
    sum_ovf = sum[cae_pkg::WordW] != sum[cae_pkg::WordW-1];
    if (sum_ovf) begin
      sum_res = sum[cae_pkg::WordW] ? cae_pkg::WordMin : cae_pkg::WordMax;
    end else begin
      sum_res = sum[cae_pkg::WordW-1:0];
    end
  end

  assign prod_d = cae_pkg::ProdW'(a_i) * cae_pkg::ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i && op_i == cae_pkg::OP_MULA) begin
      prod_q <= prod_d;
    end
  end

  // Adding 2^F-1 before the arithmetic shift makes negative products
  // truncate toward zero, as a shift of the magnitude would.
  always_comb begin
    if (prod_q[cae_pkg::ProdW-1]) begin
      biased = prod_q + {{(cae_pkg::ProdW-cae_pkg::FracW){1'b0}},
                         {cae_pkg::FracW{1'b1}}};
    end else begin
      biased = prod_q;
    end
    shifted  = biased >>> cae_pkg::FracW;
    quot     = shifted[cae_pkg::QuotW-1:0];
    quot_ovf = !((&quot[cae_pkg::QuotW-1:cae_pkg::WordW-1]) ||
                 (~|quot[cae_pkg::QuotW-1:cae_pkg::WordW-1]));
    if (quot_ovf) begin
      quot_res = quot[cae_pkg::QuotW-1] ? cae_pkg::WordMin : cae_pkg::WordMax;
    end else begin
      quot_res = quot[cae_pkg::WordW-1:0];
    end
  end

  always_comb begin
    case (op_i)
      cae_pkg::OP_ADD, cae_pkg::OP_SUB: begin
        res_o = sum_res;
        ovf_o = sum_ovf;
      end
      cae_pkg::OP_MULB: begin
        res_o = quot_res;
        ovf_o = quot_ovf;
      end
      default: begin
        res_o = '0;
        ovf_o = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/cae_ctrl.sv @@
// Sequencer that accepts requests and steps the microprogram over the shared unit.
module cae_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            restart_i,
  input  logic            out_free_i,
  output logic            in_stall_o,
  output cae_pkg::ctrl_t  ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  logic [cae_pkg::PcW-1:0]  pc_q, pc_d;
  logic                     accept;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pc_d    = '0;
          state_d = restart_i ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (pc_q == cae_pkg::PcLast) begin
          state_d = ST_DONE;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    ctrl_o.uop        = cae_pkg::Prog[pc_q];
    ctrl_o.exec       = state_q == ST_RUN;
    ctrl_o.load_start = accept && restart_i;
    ctrl_o.step_start = accept && !restart_i;
    ctrl_o.last_step  = (state_q == ST_RUN) && (pc_q == cae_pkg::PcLast);
    ctrl_o.commit     = (state_q == ST_DONE) && out_free_i;
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("request taken while the sequencer is busy");

  a_restart_skips_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && restart_i) |=> (state_q == ST_DONE))
    else $error("restart request did not go straight to output");

  a_step_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart_i) |=> (state_q == ST_RUN && pc_q == '0))
    else $error("step request did not start the program at its first entry");

  a_run_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.last_step |=> (state_q == ST_DONE))
    else $error("program end did not hand over to output");
`endif

endmodule

@@ hdl/chaotic_attractor_euler_stepper.sv @@
// Top level of the attractor stepper: configuration, point state and output register.
// Generates a three-variable chaotic trajectory by forward Euler steps in signed
// Q8.24. Each request on the input channel (in_valid_i, in_stall_o, restart_i)
// yields exactly one point on the output channel (out_valid_o, out_stall_i,
// pos_x_o, pos_y_o, pos_z_o, run_last_o, clipped_o). A request with restart_i
// high loads and emits the configured start point; otherwise one step is taken.
// A step runs a 21-entry microprogram over one shared adder and multiplier (seven
// products) in state RUN, then waits in DONE to load the output register; a restart
// goes from IDLE straight to DONE. A new request is taken in the cycle after the
// point is loaded. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must do so only while no request is in progress, as the
// block does not enforce this. Reset restores the default coefficients, puts the
// point at the default start and clears the point counter and output valid. A
// stalled receiver holds the finished point; the block still takes one more
// request meanwhile and waits with its result until the output register frees.
module chaotic_attractor_euler_stepper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [31:0] pos_z_o,
  output logic        run_last_o,
  output logic        clipped_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic [23:0] IdxMax = '1;

  logic [30:0]    sigma_q, rho_q, beta_q;
  logic [24:0]    dt_q;
  cae_pkg::word_t x0_q, y0_q, z0_q;
  logic [23:0]    count_q;

  cae_pkg::word_t x_q, y_q, z_q;
  cae_pkg::word_t t0_q, t1_q, t2_q, t3_q;
  logic [23:0]    idx_q;
  logic           clip_q;

  logic           out_valid_q;
  cae_pkg::word_t out_x_q, out_y_q, out_z_q;
  logic           out_last_q, out_clip_q;

  cae_pkg::ctrl_t ctrl;
  cae_pkg::word_t opa, opb, alu_res;
  logic           alu_ovf;
  logic           out_free;
  logic           wr_en;
  logic [23:0]    last_idx;

  assign out_free = !out_valid_q || !out_stall_i;

  cae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  function automatic cae_pkg::word_t pick(
    input cae_pkg::src_e  sel,
    input cae_pkg::word_t x, input cae_pkg::word_t y, input cae_pkg::word_t z,
    input cae_pkg::word_t t0, input cae_pkg::word_t t1,
    input cae_pkg::word_t t2, input cae_pkg::word_t t3,
    input logic [30:0] sg, input logic [30:0] rh, input logic [30:0] bt,
    input logic [24:0] dt
  );
    cae_pkg::word_t v;
    case (sel)
      cae_pkg::SRC_X:  v = x;
      cae_pkg::SRC_Y:  v = y;
      cae_pkg::SRC_Z:  v = z;
      cae_pkg::SRC_T0: v = t0;
      cae_pkg::SRC_T1: v = t1;
      cae_pkg::SRC_T2: v = t2;
      cae_pkg::SRC_T3: v = t3;
      cae_pkg::SRC_SG: v = {1'b0, sg};
      cae_pkg::SRC_RH: v = {1'b0, rh};
      cae_pkg::SRC_BT: v = {1'b0, bt};
      cae_pkg::SRC_DT: v = {7'd0, dt};
      default:         v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(ctrl.uop.src_a, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
               sigma_q, rho_q, beta_q, dt_q);
    opb = pick(ctrl.uop.src_b, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
               sigma_q, rho_q, beta_q, dt_q);
  end

  cae_alu u_alu (
    .clk_i (clk_i),
    .op_i  (ctrl.uop.op),
    .en_i  (ctrl.exec),
    .a_i   (opa),
    .b_i   (opb),
    .res_o (alu_res),
    .ovf_o (alu_ovf)
  );

  assign wr_en = ctrl.exec && (ctrl.uop.op != cae_pkg::OP_MULA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= 31'd167772160;
      rho_q   <= 31'd469762048;
      beta_q  <= 31'd44739243;
      dt_q    <= 25'd16777;
      x0_q    <= 32'sd16777216;
      y0_q    <= 32'sd16777216;
      z0_q    <= 32'sd16777216;
      count_q <= 24'd200000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cae_pkg::REG_SIGMA:   sigma_q <= cfg_wdata_i[30:0];
        cae_pkg::REG_RHO:     rho_q   <= cfg_wdata_i[30:0];
        cae_pkg::REG_BETA:    beta_q  <= cfg_wdata_i[30:0];
        cae_pkg::REG_DT:      dt_q    <= cfg_wdata_i[24:0];
        cae_pkg::REG_START_X: x0_q    <= cfg_wdata_i;
        cae_pkg::REG_START_Y: y0_q    <= cfg_wdata_i;
        cae_pkg::REG_START_Z: z0_q    <= cfg_wdata_i;
        cae_pkg::REG_COUNT:   count_q <= cfg_wdata_i[23:0];
        default: begin
        end
      endcase
    end
  end

  // Point state and the point counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= 32'sd16777216;
      y_q    <= 32'sd16777216;
      z_q    <= 32'sd16777216;
      idx_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      if (ctrl.load_start) begin
        x_q    <= x0_q;
        y_q    <= y0_q;
        z_q    <= z0_q;
        idx_q  <= '0;
        clip_q <= 1'b0;
      end else if (ctrl.step_start) begin
        clip_q <= 1'b0;
      end else if (wr_en) begin
        clip_q <= clip_q | alu_ovf;
        case (ctrl.uop.dst)
          cae_pkg::DST_X: x_q <= alu_res;
          cae_pkg::DST_Y: y_q <= alu_res;
          cae_pkg::DST_Z: z_q <= alu_res;
          default: begin
          end
        endcase
      end
      if (ctrl.last_step && idx_q != IdxMax) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Scratch values of the step.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (ctrl.uop.dst)
        cae_pkg::DST_T0: t0_q <= alu_res;
        cae_pkg::DST_T1: t1_q <= alu_res;
        cae_pkg::DST_T2: t2_q <= alu_res;
        cae_pkg::DST_T3: t3_q <= alu_res;
        default: begin
        end
      endcase
    end
  end

  // A point count of zero behaves as one, so index zero is then the last.
  assign last_idx = (count_q == '0) ? '0 : count_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_z_q    <= z_q;
      out_last_q <= idx_q == last_idx;
      out_clip_q <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign pos_z_o     = out_z_q;
  assign run_last_o  = out_last_q;
  assign clipped_o   = out_clip_q;

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for the attractor stepper: directed and random ticks, settings and stalls.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic {
    TICK_STEP    = 1'b0,
    TICK_RESTART = 1'b1
  } tick_e;

  typedef enum int unsigned {
    SET_PHYSICAL,
    SET_WIDE,
    SET_EXTREME
  } setting_e;

  typedef struct packed {
    cae_pkg::word_t x;
    cae_pkg::word_t y;
    cae_pkg::word_t z;
    logic           last;
    logic           clip;
  } point_t;

  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold = 120;
  localparam int unsigned TickTarget = 1350;
  localparam logic [31:0] RegMask [8] = '{
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h01FF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] pos_x_o;
  logic [31:0] pos_y_o;
  logic [31:0] pos_z_o;
  logic        run_last_o;
  logic        clipped_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  chaotic_attractor_euler_stepper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .run_last_o  (run_last_o),
    .clipped_o   (clipped_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5ns clk_i = ~clk_i;

  // Shadow of the register file and of the trajectory state.
  logic [31:0] reg_shadow [8] = '{
    32'd167772160, 32'd469762048, 32'd44739243, 32'd16777,
    32'd16777216, 32'd16777216, 32'd16777216, 32'd200000
  };
  longint      trk_x = 64'sd16777216;
  longint      trk_y = 64'sd16777216;
  longint      trk_z = 64'sd16777216;
  logic [23:0] trk_index = '0;
  bit          step_clip;

  tick_e       tick_q [$];
  point_t      pending_points [$];
  point_t      want;
  logic        idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned fault_count = 0;
  int unsigned ticks_queued = 0;
  int unsigned restarts_queued = 0;
  int unsigned settings_used = 0;
  int unsigned points_seen = 0;
  int unsigned clip_seen = 0;
  int unsigned last_seen = 0;
  int unsigned quiet_cycles = 0;

  function automatic longint fit_word(input longint v);
    if (v > SatHi) begin
      step_clip = 1'b1;
      return SatHi;
    end
    if (v < SatLo) begin
      step_clip = 1'b1;
      return SatLo;
    end
    return v;
  endfunction

  // Fixed-point product: the magnitude is truncated, so rounding is toward zero.
  function automatic longint q_mul(input longint a, input longint b);
    longint prod;
    longint quo;
    prod = a * b;
    quo = ((prod < 0) ? -prod : prod) >>> cae_pkg::FracW;
    return fit_word((prod < 0) ? -quo : quo);
  endfunction

  function automatic point_t advance_point(input logic restart);
    longint      sg, rh, bt, dt, ox, oy, oz, dxv, dyv, dzv;
    logic [23:0] span;
    point_t      p;
    step_clip = 1'b0;
    if (restart) begin
      trk_x = longint'($signed(reg_shadow[cae_pkg::REG_START_X]));
      trk_y = longint'($signed(reg_shadow[cae_pkg::REG_START_Y]));
      trk_z = longint'($signed(reg_shadow[cae_pkg::REG_START_Z]));
      trk_index = '0;
    end else begin
      sg = longint'(reg_shadow[cae_pkg::REG_SIGMA]);
      rh = longint'(reg_shadow[cae_pkg::REG_RHO]);
      bt = longint'(reg_shadow[cae_pkg::REG_BETA]);
      dt = longint'(reg_shadow[cae_pkg::REG_DT]);
      ox = trk_x;
      oy = trk_y;
      oz = trk_z;
      dxv = q_mul(sg, fit_word(oy - ox));
      dyv = fit_word(q_mul(ox, fit_word(rh - oz)) - oy);
      dzv = fit_word(q_mul(ox, oy) - q_mul(bt, oz));
      trk_x = fit_word(ox + q_mul(dt, dxv));
      trk_y = fit_word(oy + q_mul(dt, dyv));
      trk_z = fit_word(oz + q_mul(dt, dzv));
      if (trk_index != 24'hFF_FFFF) trk_index = trk_index + 24'd1;
    end
    span = reg_shadow[cae_pkg::REG_COUNT][23:0];
    if (span == '0) span = 24'd1;
    p.x = cae_pkg::word_t'(trk_x);
    p.y = cae_pkg::word_t'(trk_y);
    p.z = cae_pkg::word_t'(trk_z);
    p.last = (trk_index == span - 24'd1);
    p.clip = step_clip;
    return p;
  endfunction

  task automatic check_field(input string tag, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, exp_v, got_v);
      fault_count++;
    end
  endtask

  // Request driver: the prediction is made at the edge where the block takes the request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) pending_points.push_back(advance_point(restart_i));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid_i <= 1'b1;
          restart_i <= tick_q.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Point monitor and receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_points.size() == 0) begin
          $display("%0t: point emitted with none expected, got %h %h %h", $time,
                   pos_x_o, pos_y_o, pos_z_o);
          fault_count++;
        end else begin
          want = pending_points.pop_front();
          check_field("pos_x", want.x, pos_x_o);
          check_field("pos_y", want.y, pos_y_o);
          check_field("pos_z", want.z, pos_z_o);
          check_field("run_last", 32'(want.last), 32'(run_last_o));
          check_field("clipped", 32'(want.clip), 32'(clipped_o));
        end
        points_seen++;
        if (clipped_o) clip_seen++;
        if (run_last_o) last_seen++;
        // A long hold lets the block fill up and push back on the request side.
        if (points_seen == 150 || points_seen == 700) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send(input tick_e t);
    tick_q.push_back(t);
    ticks_queued++;
    if (t == TICK_RESTART) restarts_queued++;
  endtask

  // Waits until no request is queued or in flight and every point has come back.
  task automatic settle();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || pending_points.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    settings_used++;
  endtask

  task automatic cfg_write(input cae_pkg::reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    reg_shadow[idx] = val & RegMask[idx];
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_setting(input setting_e style);
    logic [31:0]   phys, wide, lo, hi, val;
    cae_pkg::reg_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = cae_pkg::reg_e'(i);
      case (idx)
        cae_pkg::REG_SIGMA:
          phys = $urandom_range(5 << cae_pkg::FracW, 15 << cae_pkg::FracW);
        cae_pkg::REG_RHO:   phys = $urandom_range(0, 50 << cae_pkg::FracW);
        cae_pkg::REG_BETA:  phys = $urandom_range(0, 4 << cae_pkg::FracW);
        cae_pkg::REG_DT:    phys = $urandom_range(1, 1 << 19);
        cae_pkg::REG_COUNT: phys = $urandom_range(1, 40);
        default:
          phys = $urandom_range(0, 60 << cae_pkg::FracW) - (30 << cae_pkg::FracW);
      endcase
      case (idx)
        cae_pkg::REG_SIGMA, cae_pkg::REG_RHO, cae_pkg::REG_BETA: begin
          lo = '0;
          hi = 32'h7FFF_FFFF;
          wide = $urandom & 32'h7FFF_FFFF;
        end
        cae_pkg::REG_DT: begin
          lo = '0;
          hi = 32'h0100_0000;
          wide = $urandom_range(0, 32'h0100_0000);
        end
        cae_pkg::REG_COUNT: begin
          lo = '0;
          hi = 32'h00FF_FFFF;
          wide = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h00FF_FFFF)
                                             : $urandom_range(0, 40);
        end
        default: begin
          lo = 32'h8000_0000;
          hi = 32'h7FFF_FFFF;
          wide = $urandom;
        end
      endcase
      case (style)
        SET_PHYSICAL: val = phys;
        SET_WIDE:     val = wide;
        default: begin
          case ($urandom_range(0, 3))
            0:       val = lo;
            1:       val = hi;
            2:       val = phys;
            default: val = wide;
          endcase
        end
      endcase
      if (style == SET_EXTREME || $urandom_range(0, 3) != 0) cfg_write(idx, val);
    end
  endtask

  initial begin
    int unsigned run_len;
    int unsigned pick;
    setting_e    style;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults, stepping before any restart.
    send(TICK_STEP);
    send(TICK_STEP);
    send(TICK_RESTART);
    send(TICK_STEP);

    // A zero point count behaves as a run of one point.
    settle();
    cfg_write(cae_pkg::REG_COUNT, 32'd0);
    cfg_close();
    send(TICK_RESTART);
    send(TICK_STEP);

    // A short run, then stepping past its end.
    settle();
    cfg_write(cae_pkg::REG_COUNT, 32'd3);
    cfg_close();
    send(TICK_RESTART);
    send(TICK_STEP);
    send(TICK_STEP);
    send(TICK_STEP);

    settle();
    cfg_write(cae_pkg::REG_SIGMA, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_RHO, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_BETA, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_DT, 32'h0100_0000);
    cfg_write(cae_pkg::REG_START_X, 32'h8000_0000);
    cfg_write(cae_pkg::REG_START_Y, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_START_Z, 32'h8000_0000);
    cfg_write(cae_pkg::REG_COUNT, 32'd1);
    cfg_close();
    send(TICK_RESTART);
    send(TICK_STEP);
    send(TICK_STEP);

    settle();
    cfg_write(cae_pkg::REG_SIGMA, 32'd0);
    cfg_write(cae_pkg::REG_RHO, 32'd0);
    cfg_write(cae_pkg::REG_BETA, 32'd0);
    cfg_write(cae_pkg::REG_DT, 32'd0);
    cfg_write(cae_pkg::REG_START_X, 32'd0);
    cfg_write(cae_pkg::REG_START_Y, 32'd0);
    cfg_write(cae_pkg::REG_START_Z, 32'd0);
    cfg_write(cae_pkg::REG_COUNT, 32'h00FF_FFFF);
    cfg_close();
    send(TICK_RESTART);
    send(TICK_STEP);
    send(TICK_STEP);

    settle();
    cfg_write(cae_pkg::REG_SIGMA, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_BETA, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_DT, 32'h0100_0000);
    cfg_write(cae_pkg::REG_START_X, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_START_Y, 32'h8000_0000);
    cfg_write(cae_pkg::REG_START_Z, 32'h7FFF_FFFF);
    cfg_write(cae_pkg::REG_COUNT, 32'd2);
    cfg_close();
    send(TICK_RESTART);
    send(TICK_STEP);
    send(TICK_STEP);
    send(TICK_STEP);

    // Random settings, each followed by a trajectory that mostly steps.
    while (ticks_queued < TickTarget) begin
      if (ticks_queued > TickTarget - 200) idle_on <= 1'b0;
      settle();
      pick = $urandom_range(0, 9);
      style = (pick < 4) ? SET_PHYSICAL : (pick < 7) ? SET_WIDE : SET_EXTREME;
      load_setting(style);
      cfg_close();
      run_len = $urandom_range(20, 80);
      for (int k = 0; k < run_len; k++) begin
        if ((k == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 14) == 0) begin
          send(TICK_RESTART);
        end else begin
          send(TICK_STEP);
        end
      end
    end

    settle();
    repeat (30) @(posedge clk_i);
    $display("Run summary: %0d ticks (%0d restarts) under %0d settings, %0d points checked.",
             ticks_queued, restarts_queued, settings_used, points_seen);
    $display("Run summary: %0d points saturated, %0d marked as last of their run.",
             clip_seen, last_seen);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
